// ----- src/assert_macros.svh -----
// Assertion helpers, included by wifi_contention_backoff.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wcb_pkg.sv -----
package wcb_pkg;

    // Field widths
    localparam int TIME_BITS  = 48;
    localparam int CW_BITS    = 10;
    localparam int SLOT_W     = 24;
    localparam int RETRY_W    = 4;
    localparam int REQ_W      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = SLOT_W;

    // Derived arithmetic widths
    localparam int PROD_W     = CW_BITS + SLOT_W;
    localparam int WAIT_W     = PROD_W + 1;
    localparam int SUM_W      = ((TIME_BITS > WAIT_W) ? TIME_BITS : WAIT_W) + 1;
    localparam int CW_SHIFT_W = CW_BITS + 1 + (2 ** RETRY_W) - 1;
    localparam int DIV_CNT_W  = $clog2(TIME_BITS);

    // Input transfer layout (tdata, lowest bit first)
    localparam int IN_MFREE_LSB = 0;
    localparam int IN_NOW_LSB   = IN_MFREE_LSB + 1;
    localparam int IN_RETRY_LSB = IN_NOW_LSB + TIME_BITS;
    localparam int IN_RAND_LSB  = IN_RETRY_LSB + RETRY_W;
    localparam int IN_BITS      = IN_RAND_LSB + CW_BITS;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

    // Output transfer layout (tdata, lowest bit first)
    localparam int OUT_ST_LSB     = 0;
    localparam int OUT_GRANT_BIT  = OUT_ST_LSB + 2;
    localparam int OUT_COLL_BIT   = OUT_GRANT_BIT + 1;
    localparam int OUT_CANCEL_BIT = OUT_COLL_BIT + 1;
    localparam int OUT_SCHED_BIT  = OUT_CANCEL_BIT + 1;
    localparam int OUT_TIME_LSB   = OUT_SCHED_BIT + 1;
    localparam int OUT_SLOTS_LSB  = OUT_TIME_LSB + TIME_BITS;
    localparam int OUT_BITS       = OUT_SLOTS_LSB + CW_BITS;
    localparam int OUT_DATA_W     = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IFS    = 3'd0,
        CFG_EIFS   = 3'd1,
        CFG_SLOT   = 3'd2,
        CFG_CW_MIN = 3'd3,
        CFG_CW_MAX = 3'd4,
        CFG_CREDIT = 3'd5
    } t_cfg_idx;

    // Event codes
    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 3'd0,
        REQ_MEDIUM  = 3'd1,
        REQ_CORRUPT = 3'd2,
        REQ_GRANT   = 3'd3,
        REQ_COLL    = 3'd4,
        REQ_RELEASE = 3'd5
    } t_req;

    // Contention states
    typedef enum logic [1:0] {
        MAC_IDLE  = 2'd0,
        MAC_DEFER = 2'd1,
        MAC_IFSBO = 2'd2,
        MAC_OWN   = 2'd3
    } t_mac_state;

    // One result transfer
    typedef struct packed {
        t_mac_state           mac_st;
        logic                 granted;
        logic                 coll;
        logic                 cancel;
        logic                 sched;
        logic [TIME_BITS-1:0] sched_time;
        logic [CW_BITS-1:0]   slots;
        logic                 err;
    } t_result;

    // Divider handshake toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // Time sum that saturates at all ones
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [WAIT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s[SUM_W-1:TIME_BITS] != '0) begin
            return '1;
        end
        return s[TIME_BITS-1:0];
    endfunction

endpackage

// ----- src/wcb_div.sv -----
// Restoring divider, one quotient bit per cycle
module wcb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wcb_pkg::TIME_BITS-1:0] i_dividend,
    input  logic [wcb_pkg::SLOT_W-1:0]    i_divisor,
    output wcb_pkg::t_div_status          o_status,
    output logic [wcb_pkg::TIME_BITS-1:0] o_quot,
    output logic [wcb_pkg::SLOT_W-1:0]    o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [wcb_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [wcb_pkg::TIME_BITS-1:0] r_quot;
    logic [wcb_pkg::SLOT_W-1:0]    r_rem;
    logic [wcb_pkg::SLOT_W-1:0]    r_divisor;

    logic [wcb_pkg::SLOT_W:0]      w_shifted;
    logic [wcb_pkg::SLOT_W+1:0]    w_diff;

    // Shift in the next dividend bit and try the subtraction
    assign w_shifted = {r_rem, r_quot[wcb_pkg::TIME_BITS-1]};
    assign w_diff    = {1'b0, w_shifted} - {2'b00, r_divisor};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= wcb_pkg::DIV_CNT_W'(wcb_pkg::TIME_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[wcb_pkg::SLOT_W+1]) begin
                r_rem  <= w_diff[wcb_pkg::SLOT_W-1:0];
                r_quot <= {r_quot[wcb_pkg::TIME_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_shifted[wcb_pkg::SLOT_W-1:0];
                r_quot <= {r_quot[wcb_pkg::TIME_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;
    assign o_rem         = r_rem;

endmodule

// ----- src/wifi_contention_backoff.sv -----
// Medium-change and corrupted-frame events that only update state, and grant, collision
//   and release events: decoded in S_DECODE, result registered from S_DONE.
// Backoff draw on start: 48-step divide in S_MOD, then, if the medium is free,
//   4 planning steps; backoff freeze on medium busy: 48-step divide in S_FRZ_DIV.
// One event in flight at a time; the shared bit-serial divider sets the rate.
// Reset (synchronous, i_rst_n low): registers to defaults, idle, medium free.
`include "assert_macros.svh"

module wifi_contention_backoff (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration writes
    input  logic                               i_cfg_we,
    input  logic [wcb_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [wcb_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Events
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // medium_free, now_time, retry_count, rand_value, zero pad
    input  logic [wcb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic [wcb_pkg::REQ_W-1:0]          s_axis_tuser,
    // Results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // fsm_state, access_granted, collision_report, cancel_request,
    // schedule_request, schedule_time, slots_left
    output logic [wcb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // event_error
    output logic                               m_axis_tuser
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_DECODE    = 10'b00_0000_0010,
        S_MOD       = 10'b00_0000_0100,
        S_PLAN_EIFS = 10'b00_0000_1000,
        S_PLAN_SUM  = 10'b00_0001_0000,
        S_PLAN_CRED = 10'b00_0010_0000,
        S_PLAN_TIME = 10'b00_0100_0000,
        S_FRZ_REM   = 10'b00_1000_0000,
        S_FRZ_DIV   = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } t_seq_state;

    t_seq_state r_state;

    // Configuration
    logic [wcb_pkg::SLOT_W-1:0]    r_ifs;
    logic [wcb_pkg::SLOT_W-1:0]    r_eifs;
    logic [wcb_pkg::SLOT_W-1:0]    r_slot;
    logic [wcb_pkg::CW_BITS-1:0]   r_cw_min;
    logic [wcb_pkg::CW_BITS-1:0]   r_cw_max;
    logic                          r_credit;

    // Contention state
    wcb_pkg::t_mac_state           r_mac_st;
    logic                          r_med_free;
    logic [wcb_pkg::CW_BITS-1:0]   r_backoff;
    logic [wcb_pkg::RETRY_W-1:0]   r_retries;
    logic [wcb_pkg::TIME_BITS-1:0] r_eifs_end;
    logic [wcb_pkg::TIME_BITS-1:0] r_last_busy;
    logic [wcb_pkg::TIME_BITS-1:0] r_planned;

    // Current event
    wcb_pkg::t_req                 r_req;
    logic                          r_ev_mfree;
    logic [wcb_pkg::TIME_BITS-1:0] r_now;
    logic [wcb_pkg::RETRY_W-1:0]   r_ev_retry;
    logic [wcb_pkg::CW_BITS-1:0]   r_ev_rnd;

    // Planning temporaries
    logic                          r_use_eifs;
    logic [wcb_pkg::PROD_W-1:0]    r_prod;
    logic [wcb_pkg::TIME_BITS-1:0] r_elapsed;
    logic [wcb_pkg::WAIT_W-1:0]    r_wait;

    // Result being built and result on the output
    wcb_pkg::t_result              r_res;
    wcb_pkg::t_result              r_out;
    logic                          r_out_valid;

    // Divider connections
    logic                          w_div_start;
    logic [wcb_pkg::TIME_BITS-1:0] w_div_dividend;
    logic [wcb_pkg::SLOT_W-1:0]    w_div_divisor;
    wcb_pkg::t_div_status          w_div_status;
    logic [wcb_pkg::TIME_BITS-1:0] w_div_quot;
    logic [wcb_pkg::SLOT_W-1:0]    w_div_rem;

    logic                          w_in_xfer;
    logic                          w_out_free;
    logic                          w_start_ok;
    logic [wcb_pkg::CW_SHIFT_W-1:0] w_cw_full;
    logic [wcb_pkg::CW_BITS-1:0]   w_cw;
    logic [wcb_pkg::TIME_BITS-1:0] w_rem_time;
    logic [wcb_pkg::TIME_BITS:0]   w_ceil;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_start_ok = (r_req == wcb_pkg::REQ_START) && (r_mac_st == wcb_pkg::MAC_IDLE);

    // Contention window: ((cw_min+1) << retry) - 1, capped at cw_max
    assign w_cw_full = (wcb_pkg::CW_SHIFT_W'(r_cw_min) + 1'b1) << r_ev_retry;
    always_comb begin
        if ((w_cw_full - 1'b1) > wcb_pkg::CW_SHIFT_W'(r_cw_max)) begin
            w_cw = r_cw_max;
        end else begin
            w_cw = wcb_pkg::CW_BITS'(w_cw_full - 1'b1);
        end
    end

    // Remaining time until the planned transfer, floored at zero
    assign w_rem_time = (r_planned > r_now) ? (r_planned - r_now) : '0;

    // Shared divider: backoff draw on start, slot count on freeze
    assign w_div_start    = ((r_state == S_DECODE) && w_start_ok) || (r_state == S_FRZ_REM);
    assign w_div_dividend = (r_state == S_FRZ_REM) ? w_rem_time
                                                   : wcb_pkg::TIME_BITS'(r_ev_rnd);
    assign w_div_divisor  = (r_state == S_FRZ_REM) ? r_slot
                                                   : wcb_pkg::SLOT_W'({1'b0, w_cw} + 1'b1);

    wcb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_status   (w_div_status),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // Ceiling of the quotient
    assign w_ceil = (wcb_pkg::TIME_BITS+1)'(w_div_quot)
                  + (wcb_pkg::TIME_BITS+1)'(w_div_rem != '0);

    // Latch the event on input transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req      <= wcb_pkg::t_req'(s_axis_tuser);
            r_ev_mfree <= s_axis_tdata[wcb_pkg::IN_MFREE_LSB];
            r_now      <= s_axis_tdata[wcb_pkg::IN_NOW_LSB +: wcb_pkg::TIME_BITS];
            r_ev_retry <= s_axis_tdata[wcb_pkg::IN_RETRY_LSB +: wcb_pkg::RETRY_W];
            r_ev_rnd   <= s_axis_tdata[wcb_pkg::IN_RAND_LSB +: wcb_pkg::CW_BITS];
        end
    end

    // Planning datapath: one wide step per state
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_PLAN_EIFS: begin
                r_use_eifs <= r_eifs_end > wcb_pkg::sat_add(r_now, wcb_pkg::WAIT_W'(r_ifs));
                r_prod     <= wcb_pkg::PROD_W'(r_backoff) * wcb_pkg::PROD_W'(r_slot);
                r_elapsed  <= (r_now >= r_last_busy) ? (r_now - r_last_busy) : '0;
            end
            S_PLAN_SUM: begin
                r_wait <= wcb_pkg::WAIT_W'(r_use_eifs ? r_eifs : r_ifs)
                        + wcb_pkg::WAIT_W'(r_prod);
            end
            S_PLAN_CRED: begin
                if (r_credit && (r_retries == '0)) begin
                    if (wcb_pkg::SUM_W'(r_elapsed) > wcb_pkg::SUM_W'(r_wait)) begin
                        r_wait <= '0;
                    end else begin
                        r_wait <= r_wait - wcb_pkg::WAIT_W'(r_elapsed);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out        <= r_res;
            r_out.mac_st <= r_mac_st;
            r_out.slots  <= r_backoff;
        end
    end

    // Sequencer, configuration and contention state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ifs       <= wcb_pkg::SLOT_W'(34000);
            r_eifs      <= wcb_pkg::SLOT_W'(94000);
            r_slot      <= wcb_pkg::SLOT_W'(9000);
            r_cw_min    <= wcb_pkg::CW_BITS'(15);
            r_cw_max    <= '1;
            r_credit    <= 1'b0;
            r_mac_st    <= wcb_pkg::MAC_IDLE;
            r_med_free  <= 1'b1;
            r_backoff   <= '0;
            r_retries   <= '0;
            r_eifs_end  <= '0;
            r_last_busy <= '0;
            r_planned   <= '0;
            r_res       <= '0;
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                unique case (wcb_pkg::t_cfg_idx'(i_cfg_addr))
                    wcb_pkg::CFG_IFS:    r_ifs    <= i_cfg_wdata;
                    wcb_pkg::CFG_EIFS:   r_eifs   <= i_cfg_wdata;
                    wcb_pkg::CFG_SLOT:   r_slot   <= i_cfg_wdata;
                    wcb_pkg::CFG_CW_MIN: r_cw_min <= i_cfg_wdata[wcb_pkg::CW_BITS-1:0];
                    wcb_pkg::CFG_CW_MAX: r_cw_max <= i_cfg_wdata[wcb_pkg::CW_BITS-1:0];
                    wcb_pkg::CFG_CREDIT: r_credit <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            // Drop the output once taken
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    r_res   <= '0;
                    r_state <= S_DONE;
                    unique case (r_req)
                        wcb_pkg::REQ_START: begin
                            if (r_mac_st == wcb_pkg::MAC_IDLE) begin
                                r_retries <= r_ev_retry;
                                r_state   <= S_MOD;
                            end else begin
                                r_res.err <= 1'b1;
                            end
                        end
                        wcb_pkg::REQ_MEDIUM: begin
                            r_med_free  <= r_ev_mfree;
                            r_last_busy <= r_now;
                            if (r_mac_st == wcb_pkg::MAC_DEFER) begin
                                if (r_ev_mfree) begin
                                    r_mac_st <= wcb_pkg::MAC_IFSBO;
                                    r_state  <= S_PLAN_EIFS;
                                end else begin
                                    r_res.err <= 1'b1;
                                end
                            end else if (r_mac_st == wcb_pkg::MAC_IFSBO) begin
                                if (!r_ev_mfree) begin
                                    r_res.cancel <= 1'b1;
                                    r_mac_st     <= wcb_pkg::MAC_DEFER;
                                    if (r_slot != '0) begin
                                        r_state <= S_FRZ_REM;
                                    end
                                end else begin
                                    r_res.err <= 1'b1;
                                end
                            end
                        end
                        wcb_pkg::REQ_CORRUPT: begin
                            if (r_mac_st == wcb_pkg::MAC_DEFER) begin
                                r_eifs_end <= wcb_pkg::sat_add(r_now,
                                                               wcb_pkg::WAIT_W'(r_eifs));
                            end else if (r_mac_st == wcb_pkg::MAC_IFSBO) begin
                                r_eifs_end   <= wcb_pkg::sat_add(r_now,
                                                                 wcb_pkg::WAIT_W'(r_eifs));
                                r_res.cancel <= 1'b1;
                                r_state      <= S_PLAN_EIFS;
                            end else if (r_mac_st == wcb_pkg::MAC_OWN) begin
                                r_res.err <= 1'b1;
                            end
                        end
                        wcb_pkg::REQ_GRANT: begin
                            if (r_mac_st == wcb_pkg::MAC_IFSBO) begin
                                r_mac_st      <= wcb_pkg::MAC_OWN;
                                r_res.granted <= 1'b1;
                            end else begin
                                r_res.err <= 1'b1;
                            end
                        end
                        wcb_pkg::REQ_COLL: begin
                            if (r_mac_st == wcb_pkg::MAC_IFSBO) begin
                                r_mac_st   <= wcb_pkg::MAC_IDLE;
                                r_res.coll <= 1'b1;
                            end else begin
                                r_res.err <= 1'b1;
                            end
                        end
                        wcb_pkg::REQ_RELEASE: begin
                            if (r_mac_st == wcb_pkg::MAC_OWN) begin
                                r_mac_st <= wcb_pkg::MAC_IDLE;
                            end else if (r_mac_st != wcb_pkg::MAC_IDLE) begin
                                r_res.err <= 1'b1;
                            end
                        end
                        default: begin
                            r_res.err <= 1'b1;
                        end
                    endcase
                end

                // Backoff draw finished: plan now or wait for the medium
                S_MOD: begin
                    if (w_div_status.done) begin
                        r_backoff <= w_div_rem[wcb_pkg::CW_BITS-1:0];
                        if (r_med_free) begin
                            r_mac_st <= wcb_pkg::MAC_IFSBO;
                            r_state  <= S_PLAN_EIFS;
                        end else begin
                            r_mac_st <= wcb_pkg::MAC_DEFER;
                            r_state  <= S_DONE;
                        end
                    end
                end

                S_PLAN_EIFS: r_state <= S_PLAN_SUM;
                S_PLAN_SUM:  r_state <= S_PLAN_CRED;
                S_PLAN_CRED: r_state <= S_PLAN_TIME;

                // Commit the planned transmit time
                S_PLAN_TIME: begin
                    r_planned        <= wcb_pkg::sat_add(r_now, r_wait);
                    r_res.sched      <= 1'b1;
                    r_res.sched_time <= wcb_pkg::sat_add(r_now, r_wait);
                    r_state          <= S_DONE;
                end

                S_FRZ_REM: r_state <= S_FRZ_DIV;

                // Freeze: backoff only ever shrinks
                S_FRZ_DIV: begin
                    if (w_div_status.done) begin
                        if (w_ceil < (wcb_pkg::TIME_BITS+1)'(r_backoff)) begin
                            r_backoff <= w_ceil[wcb_pkg::CW_BITS-1:0];
                        end
                        r_state <= S_DONE;
                    end
                end

                // Hold until the output register is free
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.err;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[wcb_pkg::OUT_ST_LSB +: 2]                    = r_out.mac_st;
        m_axis_tdata[wcb_pkg::OUT_GRANT_BIT]                      = r_out.granted;
        m_axis_tdata[wcb_pkg::OUT_COLL_BIT]                       = r_out.coll;
        m_axis_tdata[wcb_pkg::OUT_CANCEL_BIT]                     = r_out.cancel;
        m_axis_tdata[wcb_pkg::OUT_SCHED_BIT]                      = r_out.sched;
        m_axis_tdata[wcb_pkg::OUT_TIME_LSB +: wcb_pkg::TIME_BITS] = r_out.sched_time;
        m_axis_tdata[wcb_pkg::OUT_SLOTS_LSB +: wcb_pkg::CW_BITS]  = r_out.slots;
    end

    // Checks
    `ASSERT_NEXT(a_accept_decode, w_in_xfer, r_state == S_DECODE, "accepted event not decoded")
    `ASSERT_IMPL(a_err_no_sched, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[wcb_pkg::OUT_SCHED_BIT], "error result carries a schedule")
    `ASSERT_IMPL(a_grant_own, m_axis_tvalid && m_axis_tdata[wcb_pkg::OUT_GRANT_BIT], m_axis_tdata[wcb_pkg::OUT_ST_LSB +: 2] == wcb_pkg::MAC_OWN, "grant without owning state")
    `ASSERT_IMPL(a_div_done_state, w_div_status.done, (r_state == S_MOD) || (r_state == S_FRZ_DIV), "divider finished outside a divide step")

endmodule
